[rtl/allp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// allp_pkg
// Shared types and constants of the array linked list pool: operation and
// status codes, field widths and the marks written into released nodes.
// ----------------------------------------------------------------------------
package allp_pkg;

	// default pool size
	localparam int DEF_NODES = 16;

	// payload field widths
	localparam int ID_W    = 32;
	localparam int GRADE_W = 32;
	localparam int IDX_W   = 4;
	localparam int SPTR_W  = 5;

	// marks held by a free node: id all ones, grade the pattern of -1.0
	localparam logic [ID_W-1:0]    ID_MARK    = 32'hFFFF_FFFF;
	localparam logic [GRADE_W-1:0] GRADE_MARK = 32'hBF80_0000;

	// operation codes
	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_DELETE = 2'd1,
		FN_READ   = 2'd2,
		FN_NOP    = 2'd3
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_FULL    = 2'd1,
		STS_EMPTY   = 2'd2,
		STS_NO_NEXT = 2'd3
	} status_t;

endpackage : allp_pkg
`default_nettype wire

[rtl/allp_store.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// allp_store
// Node storage of the pool: a link memory with one write and two read ports
// and a data memory (id and grade) with one write and one read port. All
// reads are registered.
// ----------------------------------------------------------------------------
module allp_store #(
	parameter int NODES = allp_pkg::DEF_NODES,
	parameter int IW    = $clog2(NODES),
	parameter int PW    = IW + 1
) (
	input  wire logic                       clk,
	// link memory
	input  wire logic                       link_we,
	input  wire logic [IW-1:0]              link_wa,
	input  wire logic [PW-1:0]              link_wd,
	input  wire logic [IW-1:0]              link_ra,
	input  wire logic [IW-1:0]              link_rb,
	output logic      [PW-1:0]              link_qa,
	output logic      [PW-1:0]              link_qb,
	// data memory
	input  wire logic                       data_we,
	input  wire logic [IW-1:0]              data_wa,
	input  wire logic [allp_pkg::ID_W-1:0]    data_wid,
	input  wire logic [allp_pkg::GRADE_W-1:0] data_wgrade,
	input  wire logic [IW-1:0]              data_ra,
	output logic      [allp_pkg::ID_W-1:0]    data_qid,
	output logic      [allp_pkg::GRADE_W-1:0] data_qgrade
);
	import allp_pkg::*;

	logic [PW-1:0]              link_mem [NODES];
	logic [ID_W+GRADE_W-1:0]    data_mem [NODES];

	// link memory: write port, two registered read ports
	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
		link_qa <= link_mem[link_ra];
		link_qb <= link_mem[link_rb];
	end

	// data memory: grade in the upper half
	always_ff @(posedge clk) begin
		if (data_we) begin
			data_mem[data_wa] <= {data_wgrade, data_wid};
		end
		{data_qgrade, data_qid} <= data_mem[data_ra];
	end

endmodule : allp_store
`default_nettype wire

[rtl/array_linked_list_pool.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// array_linked_list_pool
// Fixed pool of nodes holding one singly linked list and a free list.
// Insert, delete and read requests come in on the slave stream, one status
// and snapshot result per request goes out on the master stream.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser: func, at_head
//                                              tdata: index, item_id, item_grade
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: status ... list_full
//
//  Insert or delete at the head, read, and any rejected request run in S_EXEC
//  only; insert after a node adds S_WR2 (second link write); delete after a
//  node adds S_RD2 and S_WR2 (dependent link read, then two link writes). The
//  single write port of the link memory and the chained link read set this.
//  Reset: a clearing pass over all NODES nodes rebuilds the pool; no request is
//  taken until it ends. A result waits in the output register while the next
//  request is taken; a stalled output holds back the next result and new requests.
// ----------------------------------------------------------------------------
module array_linked_list_pool #(
	parameter int NODES = allp_pkg::DEF_NODES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// requests
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [71:0] s_axis_tdata,  // index[3:0], item_id[35:4], item_grade[67:36]
	input  wire logic [2:0]  s_axis_tuser,  // func[1:0], at_head[2]
	// results
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [87:0]      m_axis_tdata   // status[1:0], node_index[6:2],
	                                        // next_index[11:7], node_id[43:12],
	                                        // node_grade[75:44], list_head[80:76],
	                                        // free_head[85:81], list_empty[86],
	                                        // list_full[87]
);
	import allp_pkg::*;

	localparam int IW = $clog2(NODES);
	localparam int PW = IW + 1;
	localparam int EW = (PW > SPTR_W) ? PW : SPTR_W;
	localparam logic [PW-1:0] NIL = {PW{1'b1}};
	localparam logic [IW-1:0] LAST = IW'(NODES - 1);

	typedef enum logic [4:0] {
		S_INIT = 5'b00001,
		S_IDLE = 5'b00010,
		S_EXEC = 5'b00100,
		S_RD2  = 5'b01000,
		S_WR2  = 5'b10000
	} state_t;

	// pointer to the 5-bit signed result form
	function automatic logic [SPTR_W-1:0] to_sptr(input logic [PW-1:0] p);
		logic signed [EW-1:0] e;
		e = EW'(signed'(p));
		return e[SPTR_W-1:0];
	endfunction

	state_t               state_q, state_d;
	logic [IW-1:0]        clr_q;
	logic [PW-1:0]        head_q, head_d;
	logic [PW-1:0]        free_q, free_d;

	// latched request
	func_t                func_q;
	logic                 at_head_q;
	logic [IDX_W-1:0]     idx_q;
	logic [ID_W-1:0]      id_q;
	logic [GRADE_W-1:0]   grade_q;

	// pending result
	logic                 res_pend_q;
	logic                 res_load;
	status_t              res_status_q, res_status_d;
	logic [PW-1:0]        res_node_q, res_node_d;
	logic [PW-1:0]        res_next_q, res_next_d;
	logic [ID_W-1:0]      res_id_q, res_id_d;
	logic [GRADE_W-1:0]   res_grade_q, res_grade_d;

	// deferred second link write
	logic [IW-1:0]        wr2_addr_q, wr2_addr_d;
	logic [PW-1:0]        wr2_data_q, wr2_data_d;

	// output register
	logic                 m_valid_q;
	logic [87:0]          m_data_q;

	// memory ports
	logic                 link_we;
	logic [IW-1:0]        link_wa, link_ra, link_rb;
	logic [PW-1:0]        link_wd, link_qa, link_qb;
	logic                 data_we;
	logic [IW-1:0]        data_wa, data_ra;
	logic [ID_W-1:0]      data_wid, data_qid;
	logic [GRADE_W-1:0]   data_wgrade, data_qgrade;

	logic                 s_accept, out_free, idx_ok;
	func_t                in_func;
	logic [IW-1:0]        pred;

	allp_store #(
		.NODES (NODES),
		.IW    (IW),
		.PW    (PW)
	) u_store (
		.clk         (clk),
		.link_we     (link_we),
		.link_wa     (link_wa),
		.link_wd     (link_wd),
		.link_ra     (link_ra),
		.link_rb     (link_rb),
		.link_qa     (link_qa),
		.link_qb     (link_qb),
		.data_we     (data_we),
		.data_wa     (data_wa),
		.data_wid    (data_wid),
		.data_wgrade (data_wgrade),
		.data_ra     (data_ra),
		.data_qid    (data_qid),
		.data_qgrade (data_qgrade)
	);

	// handshake
	assign out_free      = !m_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && (!res_pend_q || out_free);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign in_func = func_t'(s_axis_tuser[1:0]);
	assign pred    = IW'(idx_q);
	assign idx_ok  = 32'(idx_q) < 32'(NODES);

	// read addresses: from the request while idle, then from latched values
	always_comb begin
		if (state_q == S_IDLE) begin
			link_ra = (in_func == FN_INSERT) ? free_q[IW-1:0] : head_q[IW-1:0];
			link_rb = IW'(s_axis_tdata[3:0]);
			data_ra = IW'(s_axis_tdata[3:0]);
		end else begin
			link_ra = link_qb[IW-1:0];
			link_rb = pred;
			data_ra = pred;
		end
	end

	// sequencer: writes, pointer updates, result
	always_comb begin
		state_d      = state_q;
		head_d       = head_q;
		free_d       = free_q;
		link_we      = 1'b0;
		link_wa      = pred;
		link_wd      = free_q;
		data_we      = 1'b0;
		data_wa      = pred;
		data_wid     = ID_MARK;
		data_wgrade  = GRADE_MARK;
		wr2_addr_d   = wr2_addr_q;
		wr2_data_d   = wr2_data_q;
		res_load     = 1'b0;
		res_status_d = STS_OK;
		res_node_d   = NIL;
		res_next_d   = NIL;
		res_id_d     = '0;
		res_grade_d  = '0;
		unique case (state_q)
			S_INIT: begin
				// rebuild the pool, one node a cycle
				link_we = 1'b1;
				link_wa = clr_q;
				link_wd = (clr_q == LAST) ? NIL : PW'(clr_q) + PW'(1);
				data_we = 1'b1;
				data_wa = clr_q;
				if (clr_q == LAST) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (s_accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				res_load = 1'b1;
				state_d  = S_IDLE;
				unique case (func_q)
					FN_INSERT: begin
						if (free_q == NIL) begin
							res_status_d = STS_FULL;
						end else if (!at_head_q && !idx_ok) begin
							res_status_d = STS_NO_NEXT;
						end else begin
							res_node_d  = free_q;
							data_we     = 1'b1;
							data_wa     = free_q[IW-1:0];
							data_wid    = id_q;
							data_wgrade = grade_q;
							link_we     = 1'b1;
							link_wa     = free_q[IW-1:0];
							link_wd     = at_head_q ? head_q : link_qb;
							free_d      = link_qa;
							if (at_head_q) begin
								head_d = free_q;
							end else begin
								wr2_addr_d = pred;
								wr2_data_d = free_q;
								state_d    = S_WR2;
							end
						end
					end
					FN_DELETE: begin
						if (head_q == NIL) begin
							res_status_d = STS_EMPTY;
						end else if (at_head_q) begin
							res_node_d = head_q;
							link_we    = 1'b1;
							link_wa    = head_q[IW-1:0];
							link_wd    = free_q;
							data_we    = 1'b1;
							data_wa    = head_q[IW-1:0];
							head_d     = link_qa;
							free_d     = head_q;
						end else if (!idx_ok || link_qb == NIL) begin
							res_status_d = STS_NO_NEXT;
						end else begin
							// fetch the link of the victim next
							res_node_d = link_qb;
							state_d    = S_RD2;
						end
					end
					FN_READ: begin
						if (!idx_ok) begin
							res_status_d = STS_NO_NEXT;
						end else begin
							res_node_d  = PW'(idx_q);
							res_next_d  = link_qb;
							res_id_d    = data_qid;
							res_grade_d = data_qgrade;
						end
					end
					default: begin
						res_status_d = STS_OK;
					end
				endcase
			end
			S_RD2: begin
				// unlink the victim, mark it, push it on the free list
				link_we    = 1'b1;
				link_wa    = pred;
				link_wd    = link_qa;
				data_we    = 1'b1;
				data_wa    = res_node_q[IW-1:0];
				free_d     = res_node_q;
				wr2_addr_d = res_node_q[IW-1:0];
				wr2_data_d = free_q;
				state_d    = S_WR2;
			end
			S_WR2: begin
				link_we = 1'b1;
				link_wa = wr2_addr_q;
				link_wd = wr2_data_q;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_INIT;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_INIT;
			clr_q      <= '0;
			head_q     <= NIL;
			free_q     <= '0;
			res_pend_q <= 1'b0;
			m_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			if (state_q == S_INIT) begin
				clr_q <= clr_q + IW'(1);
			end
			// result becomes pending when the request finishes
			if (state_d == S_IDLE && (state_q == S_EXEC || state_q == S_WR2)) begin
				res_pend_q <= 1'b1;
			end else if (state_q == S_IDLE && res_pend_q && out_free) begin
				res_pend_q <= 1'b0;
			end
			// output register valid
			if (state_q == S_IDLE && res_pend_q && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_accept) begin
			func_q    <= in_func;
			at_head_q <= s_axis_tuser[2];
			idx_q     <= s_axis_tdata[3:0];
			id_q      <= s_axis_tdata[35:4];
			grade_q   <= s_axis_tdata[67:36];
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_node_q   <= res_node_d;
			res_next_q   <= res_next_d;
			res_id_q     <= res_id_d;
			res_grade_q  <= res_grade_d;
		end
		wr2_addr_q <= wr2_addr_d;
		wr2_data_q <= wr2_data_d;
		// pointers are final by the time a pending result is pushed
		if (state_q == S_IDLE && res_pend_q && out_free) begin
			m_data_q <= {free_q == NIL, head_q == NIL, to_sptr(free_q), to_sptr(head_q),
				res_grade_q, res_id_q, to_sptr(res_next_q), to_sptr(res_node_q),
				res_status_q};
		end
	end

	// checks
	a_exec_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> state_q == S_EXEC)
		else $error("request accepted but not executed");

	a_exec_only_from_accept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC |-> $past(s_accept))
		else $error("execute without an accepted request");

	a_rd2_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD2 |=> state_q == S_WR2)
		else $error("chained delete did not reach its second write");

	a_pending_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_pend_q && !out_free |=> res_pend_q)
		else $error("pending result dropped while output stalled");

endmodule : array_linked_list_pool
`default_nettype wire

[tb/tb_array_linked_list_pool.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_array_linked_list_pool
// Self-checking bench for the linked list pool. A local copy of the pool
// (list head, free head, node links and payload) predicts every result.
// Requests go in on the slave stream with random gaps. Results are compared
// field by field on the master stream, with random stalls and one long hold.
// ----------------------------------------------------------------------------
module tb_array_linked_list_pool;
	import allp_pkg::*;

	localparam int NODES        = DEF_NODES;
	localparam int NIL          = -1;
	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 20;
	localparam int LONG_HOLD    = 100;

	// result layout, lowest field last
	typedef struct packed {
		logic              list_full;
		logic              list_empty;
		logic [SPTR_W-1:0] free_head;
		logic [SPTR_W-1:0] list_head;
		logic [31:0]       node_grade;
		logic [31:0]       node_id;
		logic [SPTR_W-1:0] next_index;
		logic [SPTR_W-1:0] node_index;
		logic [1:0]        status;
	} pool_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata = '0;  // index[3:0], item_id[35:4], item_grade[67:36]
	logic [2:0]  s_axis_tuser = '0;  // func[1:0], at_head[2]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [87:0] m_axis_tdata;       // status, node_index, next_index, node_id,
	                                 // node_grade, list_head, free_head,
	                                 // list_empty, list_full

	array_linked_list_pool #(.NODES(NODES)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// shadow pool
	logic [31:0]  pool_id[NODES];
	logic [31:0]  pool_grade[NODES];
	int           pool_link[NODES];
	int           list_top;
	int           free_top;

	pool_result_t expected_q[$];
	int           fail_count;
	int           sent_count;
	int           status_tally[4];
	int           cycle_count = 0;
	int           longest_hold;
	bit           tx_steady;
	bit           rx_steady;
	int           rx_hold;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				expected_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [SPTR_W-1:0] enc_ptr(int v);
		return v[SPTR_W-1:0];
	endfunction

	function automatic void pool_clear();
		for (int i = 0; i < NODES; i++) begin
			pool_id[i]    = ID_MARK;
			pool_grade[i] = GRADE_MARK;
			pool_link[i]  = (i + 1 < NODES) ? i + 1 : NIL;
		end
		list_top = NIL;
		free_top = 0;
	endfunction

	// a freed node goes on top of the free chain with its payload marked
	function automatic void pool_release(int t);
		pool_link[t]  = free_top;
		pool_id[t]    = ID_MARK;
		pool_grade[t] = GRADE_MARK;
		free_top      = t;
	endfunction

	// apply one request to the shadow pool and return what the block must report
	function automatic pool_result_t pool_apply(func_t fn, bit at_head, logic [IDX_W-1:0] idx,
			logic [31:0] id, logic [31:0] grade);
		pool_result_t r;
		status_t      sts;
		int           pred;
		bit           idx_ok;
		int           t;
		int           node;
		int           link_out;
		logic [31:0]  rid;
		logic [31:0]  rgrade;
		sts      = STS_OK;
		pred     = int'(idx);
		idx_ok   = pred < NODES;
		node     = NIL;
		link_out = NIL;
		rid      = '0;
		rgrade   = '0;
		case (fn)
			FN_INSERT: begin
				if (free_top == NIL) begin
					sts = STS_FULL;
				end else if (!at_head && !idx_ok) begin
					sts = STS_NO_NEXT;
				end else begin
					t              = free_top;
					free_top       = pool_link[t];
					pool_id[t]     = id;
					pool_grade[t]  = grade;
					if (at_head) begin
						pool_link[t] = list_top;
						list_top     = t;
					end else begin
						pool_link[t]    = pool_link[pred];
						pool_link[pred] = t;
					end
					node = t;
				end
			end
			FN_DELETE: begin
				if (list_top == NIL) begin
					sts = STS_EMPTY;
				end else if (at_head) begin
					t        = list_top;
					list_top = pool_link[t];
					pool_release(t);
					node = t;
				end else if (!idx_ok || pool_link[pred] == NIL) begin
					sts = STS_NO_NEXT;
				end else begin
					t               = pool_link[pred];
					pool_link[pred] = pool_link[t];
					pool_release(t);
					node = t;
				end
			end
			FN_READ: begin
				if (!idx_ok) begin
					sts = STS_NO_NEXT;
				end else begin
					node     = pred;
					link_out = pool_link[pred];
					rid      = pool_id[pred];
					rgrade   = pool_grade[pred];
				end
			end
			default: ;
		endcase
		status_tally[sts]++;
		r.status     = sts;
		r.node_index = enc_ptr(node);
		r.next_index = enc_ptr(link_out);
		r.node_id    = rid;
		r.node_grade = rgrade;
		r.list_head  = enc_ptr(list_top);
		r.free_head  = enc_ptr(free_top);
		r.list_empty = (list_top == NIL);
		r.list_full  = (free_top == NIL);
		return r;
	endfunction

	// random member of the list, or any node when the list is empty
	function automatic int pick_listed();
		int members[$];
		int p;
		int n;
		p = list_top;
		n = 0;
		while (p != NIL && n < NODES) begin
			members.push_back(p);
			p = pool_link[p];
			n++;
		end
		if (members.size() == 0)
			return $urandom_range(0, NODES - 1);
		return members[$urandom_range(0, members.size() - 1)];
	endfunction

	// one request transfer; valid stays high when the next one follows at once
	task automatic send_request(func_t fn, bit at_head, logic [IDX_W-1:0] idx,
			logic [31:0] id, logic [31:0] grade);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= {at_head, fn};
		s_axis_tdata  <= {4'b0, grade, id, idx};
		do @(posedge clk); while (!s_axis_tready);
		expected_q.push_back(pool_apply(fn, at_head, idx, id, grade));
		sent_count++;
	endtask

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endfunction

	// result side: random stalls, optional long hold, field checks
	initial begin
		pool_result_t got;
		pool_result_t want;
		int           stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 3);
			if (rx_hold > 0) begin
				stall   = rx_hold;
				rx_hold = 0;
			end
			if (stall > longest_hold)
				longest_hold = stall;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			got = m_axis_tdata;
			if (expected_q.size() == 0) begin
				fail_count++;
				$error("result transfer with no request pending: %h", m_axis_tdata);
			end else begin
				want = expected_q.pop_front();
				check_field("status", want.status, got.status);
				check_field("node_index", want.node_index, got.node_index);
				check_field("next_index", want.next_index, got.next_index);
				check_field("node_id", want.node_id, got.node_id);
				check_field("node_grade", want.node_grade, got.node_grade);
				check_field("list_head", want.list_head, got.list_head);
				check_field("free_head", want.free_head, got.free_head);
				check_field("list_empty", want.list_empty, got.list_empty);
				check_field("list_full", want.list_full, got.list_full);
			end
		end
	end

	// reset contents, empty-list errors, head and tail edits, unused opcode
	task automatic test_directed();
		send_request(FN_READ, 1'b0, 4'd0, '0, '0);
		send_request(FN_READ, 1'b0, 4'd15, '1, '1);
		send_request(FN_DELETE, 1'b1, 4'd0, '0, '0);
		send_request(FN_DELETE, 1'b0, 4'd5, '0, '0);
		send_request(FN_NOP, 1'b1, 4'd15, '1, '1);
		send_request(FN_INSERT, 1'b1, 4'd0, 32'h0, 32'h0);
		send_request(FN_INSERT, 1'b1, 4'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// after the tail
		send_request(FN_INSERT, 1'b0, 4'd0, 32'h0000_1234, GRADE_MARK);
		send_request(FN_READ, 1'b0, 4'd1, '0, '0);
		send_request(FN_READ, 1'b0, 4'd0, '0, '0);
		send_request(FN_READ, 1'b0, 4'd2, '0, '0);
		// nothing follows the tail
		send_request(FN_DELETE, 1'b0, 4'd2, '0, '0);
		send_request(FN_DELETE, 1'b0, 4'd1, '0, '0);
		send_request(FN_READ, 1'b0, 4'd0, '0, '0);
		// head insert ignores the index
		send_request(FN_INSERT, 1'b1, 4'd7, 32'h8000_0001, 32'h7FFF_FFFE);
		send_request(FN_DELETE, 1'b1, 4'd15, '1, '1);
		send_request(FN_DELETE, 1'b1, 4'd0, '0, '0);
		send_request(FN_DELETE, 1'b1, 4'd0, '0, '0);
		send_request(FN_DELETE, 1'b1, 4'd0, '0, '0);
		send_request(FN_NOP, 1'b0, 4'd0, '0, '0);
	endtask

	// fill the pool past full, read every node, then drain past empty
	task automatic test_fill_drain();
		for (int i = 0; i <= NODES; i++)
			send_request(FN_INSERT, 1'($urandom_range(0, 1)), 4'(pick_listed()), $urandom,
				$urandom);
		send_request(FN_INSERT, 1'b0, 4'(pick_listed()), $urandom, $urandom);
		for (int i = 0; i < NODES; i++)
			send_request(FN_READ, 1'b0, 4'(i), $urandom, $urandom);
		for (int i = 0; i <= NODES; i++)
			send_request(FN_DELETE, 1'b1, 4'($urandom_range(0, NODES - 1)), $urandom, $urandom);
	endtask

	// one random request on well-formed positions; reads may hit any node
	task automatic send_random(int insert_bias);
		func_t fn;
		int    roll;
		int    idx;
		roll = $urandom_range(0, 99);
		if (roll < 3)
			fn = FN_NOP;
		else if (roll < 25)
			fn = FN_READ;
		else if ($urandom_range(0, 99) < insert_bias)
			fn = FN_INSERT;
		else
			fn = FN_DELETE;
		if (fn == FN_READ && $urandom_range(0, 3) == 0)
			idx = $urandom_range(0, NODES - 1);
		else
			idx = pick_listed();
		send_request(fn, 1'($urandom_range(0, 1)), 4'(idx), $urandom, $urandom);
	endtask

	// phases alternate between growing and shrinking so full and empty recur
	task automatic test_random_mix(int rounds, int per_round);
		for (int r = 0; r < rounds; r++)
			for (int i = 0; i < per_round; i++)
				send_random((r % 2 == 0) ? 68 : 28);
	endtask

	// long output hold while requests keep coming back to back
	task automatic test_output_hold(int count);
		rx_hold   = LONG_HOLD;
		tx_steady = 1'b1;
		for (int i = 0; i < count; i++)
			send_random(50);
		tx_steady = 1'b0;
	endtask

	// no idling on either side
	task automatic test_full_rate(int count);
		tx_steady = 1'b1;
		rx_steady = 1'b1;
		for (int i = 0; i < count; i++)
			send_random(50);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// predecessors anywhere in the pool; free chain gets rewired as asked
	task automatic test_unlisted_links(int count);
		func_t fn;
		for (int i = 0; i < count; i++) begin
			fn = func_t'($urandom_range(0, 3));
			send_request(fn, 1'($urandom_range(0, 3) == 0), 4'($urandom_range(0, NODES - 1)),
				$urandom, $urandom);
		end
	endtask

	initial begin
		fail_count   = 0;
		sent_count   = 0;
		longest_hold = 0;
		tx_steady    = 1'b0;
		rx_steady    = 1'b0;
		rx_hold      = 0;
		status_tally = '{default: 0};
		pool_clear();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_fill_drain();
		test_random_mix(8, 60);
		test_output_hold(30);
		test_full_rate(50);
		test_unlisted_links(40);
		s_axis_tvalid <= 1'b0;

		// let the last results out
		wait (expected_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_q.size() != 0) begin
			fail_count++;
			$error("%0d results never arrived", expected_q.size());
		end

		$display("covered %0d requests: %0d ok, %0d full, %0d empty, %0d no successor",
			sent_count, status_tally[STS_OK], status_tally[STS_FULL], status_tally[STS_EMPTY],
			status_tally[STS_NO_NEXT]);
		$display("longest output hold %0d cycles, %0d mismatches, %0d cycles", longest_hold,
			fail_count, cycle_count);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
